// ===== design/extent_range_lookup_core_assert.svh =====
// Assertion macros of the extent lookup RTL.
`ifndef EXTENT_RANGE_LOOKUP_CORE_ASSERT_SVH
`define EXTENT_RANGE_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define ERL_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("extent lookup: implication check failed");

// Next-cycle implication, disabled while in reset.
`define ERL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("extent lookup: next-cycle check failed");

`endif

// ===== design/erl_pkg.sv =====
// Shared constants and types of the extent lookup block.
`default_nettype none

package erl_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int MEMBER_DISKS  = 4;

	localparam int IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
	localparam int SECT_W   = 48;
	localparam int PHYS_W   = SECT_W + 1;
	localparam int SLOT_W   = 4;
	localparam int DISK_W   = 2;
	localparam int ACTIVE_W = 5;

	// s_tdata layout, lowest bit first
	localparam int SECTOR_LSB = 0;
	localparam int SLOT_LSB   = SECTOR_LSB + SECT_W;
	localparam int START_LSB  = SLOT_LSB + SLOT_W;
	localparam int LENGTH_LSB = START_LSB + SECT_W;
	localparam int BASE_LSB   = LENGTH_LSB + SECT_W;
	localparam int DISK_LSB   = BASE_LSB + SECT_W;
	localparam int S_RAW_W    = DISK_LSB + DISK_W;
	localparam int S_TDATA_W  = ((S_RAW_W + 7) / 8) * 8;

	// m_tdata layout, lowest bit first
	localparam int M_RAW_W    = DISK_W + PHYS_W;
	localparam int M_TDATA_W  = ((M_RAW_W + 7) / 8) * 8;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_WRITE  = 1'b1;

	// Stored extent: start, exclusive end, and (base - start) mod 2^49
	typedef struct packed {
		logic [SECT_W-1:0] start;
		logic [PHYS_W-1:0] lim;
		logic [PHYS_W-1:0] delta;
		logic [DISK_W-1:0] disk;
	} entry_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} tbl_ctl_t;

endpackage

`default_nettype wire

// ===== design/erl_table.sv =====
// Extent table memory: one write port, one read port with registered data.
`default_nettype none

module erl_table (
	input  wire logic             clk,
	input  erl_pkg::tbl_ctl_t     ctl,
	input  erl_pkg::entry_t       wr_data,
	output erl_pkg::entry_t       rd_data
);

	erl_pkg::entry_t mem [erl_pkg::TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[ctl.rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/extent_range_lookup_core.sv =====
// Extent lookup: translates logical sectors to (disk, physical sector).
//
// Input stream s_*: one request per handshake. s_tuser[0] is the mode:
// 0 looks up s_tdata's logical sector, 1 writes one table entry. A write
// is done at acceptance and gives no response. A lookup scans entries
// 0 .. active_entries-1 in order, one memory read per cycle, stopping at
// the first extent that holds the sector.
// Output stream m_*: one response per lookup; m_tuser[0] is the hit flag,
// m_tdata holds disk index and physical sector (both zero on a miss).
// A lookup passes the table read register, the compare into the result
// registers and then the output register (with active_entries = 0 it
// goes straight to a miss in the result registers). No new request is
// taken until the response reaches the output register; the scan through
// the single read port of the table memory limits the lookup rate.
// cfg_*: writes active_entries (values above the table depth act as the
// depth); write only while the block is idle.
// Reset clears the control state and active_entries; table contents stay
// undefined until written. If the receiver stalls, the response holds in
// the output register and a finished second lookup waits before leaving.
`default_nettype none

module extent_range_lookup_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request: lookup_sector, entry_slot, entry_start, entry_length,
	// entry_base, entry_disk, zero pad
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [erl_pkg::S_TDATA_W-1:0]  s_tdata,
	input  wire logic [0:0]                     s_tuser,    // mode
	// response: disk_index, physical_sector, zero pad
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [erl_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic      [0:0]                     m_tuser,    // hit
	// active_entries register
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [erl_pkg::ACTIVE_W-1:0]   cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                           state_q;
	logic [erl_pkg::ACTIVE_W-1:0]     active_q;
	logic [erl_pkg::SECT_W-1:0]       sector_q;
	logic [erl_pkg::CNT_W-1:0]        limit_q;
	logic [erl_pkg::CNT_W-1:0]        idx_q;
	logic                             chk_s1;   // table data valid for compare
	logic                             last_s1;  // that entry is the last one
	logic                             res_hit_q;
	logic [erl_pkg::DISK_W-1:0]       res_disk_q;
	logic [erl_pkg::PHYS_W-1:0]       res_phys_q;
	logic                             m_valid_q;
	logic                             m_hit_q;
	logic [erl_pkg::DISK_W-1:0]       m_disk_q;
	logic [erl_pkg::PHYS_W-1:0]       m_phys_q;

	erl_pkg::tbl_ctl_t                tbl_ctl;
	erl_pkg::entry_t                  wr_entry;
	erl_pkg::entry_t                  rd_entry;

	logic                             s_acc;
	logic                             in_mode;
	logic [erl_pkg::SECT_W-1:0]       in_sector;
	logic [erl_pkg::SLOT_W-1:0]       in_slot;
	logic [erl_pkg::SECT_W-1:0]       in_start;
	logic [erl_pkg::SECT_W-1:0]       in_length;
	logic [erl_pkg::SECT_W-1:0]       in_base;
	logic [erl_pkg::DISK_W-1:0]       in_disk;
	logic [erl_pkg::CNT_W-1:0]        sat_limit;
	logic                             issue;
	logic                             match;
	logic                             stop;
	logic [erl_pkg::PHYS_W-1:0]       phys;
	logic                             out_free;

	assign in_mode   = s_tuser[0];
	assign in_sector = s_tdata[erl_pkg::SECTOR_LSB +: erl_pkg::SECT_W];
	assign in_slot   = s_tdata[erl_pkg::SLOT_LSB   +: erl_pkg::SLOT_W];
	assign in_start  = s_tdata[erl_pkg::START_LSB  +: erl_pkg::SECT_W];
	assign in_length = s_tdata[erl_pkg::LENGTH_LSB +: erl_pkg::SECT_W];
	assign in_base   = s_tdata[erl_pkg::BASE_LSB   +: erl_pkg::SECT_W];
	assign in_disk   = s_tdata[erl_pkg::DISK_LSB   +: erl_pkg::DISK_W];

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// active_entries above the depth searches the whole table
	assign sat_limit = (32'(active_q) > erl_pkg::TABLE_ENTRIES)
		? erl_pkg::CNT_W'(erl_pkg::TABLE_ENTRIES)
		: erl_pkg::CNT_W'(active_q);

	// End and base offset are folded in at write time, so the lookup
	// needs only two compares and one add per entry.
	assign wr_entry.start = in_start;
	assign wr_entry.lim   = {1'b0, in_start} + {1'b0, in_length};
	assign wr_entry.delta = {1'b0, in_base} - {1'b0, in_start};
	assign wr_entry.disk  = in_disk;

	assign issue = (state_q == ST_SCAN) && (idx_q < limit_q) && !stop;

	always_comb begin
		tbl_ctl.wr_en   = s_acc && (in_mode == erl_pkg::MODE_WRITE)
			&& (32'(in_slot) < erl_pkg::TABLE_ENTRIES);
		tbl_ctl.wr_addr = erl_pkg::IDX_W'(in_slot);
		tbl_ctl.rd_en   = issue;
		tbl_ctl.rd_addr = idx_q[erl_pkg::IDX_W-1:0];
	end

	erl_table u_table (
		.clk     (clk),
		.ctl     (tbl_ctl),
		.wr_data (wr_entry),
		.rd_data (rd_entry)
	);

	// Compare stage on the registered table data
	assign match = (sector_q >= rd_entry.start)
		&& ({1'b0, sector_q} < rd_entry.lim);
	assign phys  = {1'b0, sector_q} + rd_entry.delta;
	assign stop  = chk_s1 && (match || last_s1);

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			active_q   <= '0;
			sector_q   <= '0;
			limit_q    <= '0;
			idx_q      <= '0;
			chk_s1     <= 1'b0;
			last_s1    <= 1'b0;
			res_hit_q  <= 1'b0;
			res_disk_q <= '0;
			res_phys_q <= '0;
			m_valid_q  <= 1'b0;
			m_hit_q    <= 1'b0;
			m_disk_q   <= '0;
			m_phys_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				active_q <= cfg_data;
			end
			// ST_DONE refills the output register itself
			if (m_valid_q && m_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					chk_s1 <= 1'b0;
					if (s_acc && (in_mode == erl_pkg::MODE_LOOKUP)) begin
						sector_q   <= in_sector;
						limit_q    <= sat_limit;
						idx_q      <= '0;
						res_hit_q  <= 1'b0;
						res_disk_q <= '0;
						res_phys_q <= '0;
						// nothing to search: straight to a miss
						state_q    <= (sat_limit == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_s1  <= issue;
					last_s1 <= (idx_q == limit_q - erl_pkg::CNT_W'(1));
					if (issue) begin
						idx_q <= idx_q + erl_pkg::CNT_W'(1);
					end
					if (stop) begin
						res_hit_q  <= match;
						res_disk_q <= match ? rd_entry.disk : '0;
						res_phys_q <= match ? phys : '0;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					chk_s1 <= 1'b0;
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_hit_q   <= res_hit_q;
						m_disk_q  <= res_disk_q;
						m_phys_q  <= res_phys_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_hit_q;
	assign m_tdata  = erl_pkg::M_TDATA_W'({m_phys_q, m_disk_q});

	`include "extent_range_lookup_core_assert.svh"

	// no compare data in flight while new requests are taken
	`ERL_ASSERT_IMPLY(a_idle_no_compare, s_tready, !chk_s1)
	// a miss carries all-zero data
	`ERL_ASSERT_IMPLY(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0)
	// the scan never reads past the searched range
	`ERL_ASSERT_IMPLY(a_scan_bound, state_q == ST_SCAN, idx_q <= limit_q && limit_q != '0)
	// a finished lookup reaches the output register when it is free
	`ERL_ASSERT_NEXT(a_done_moves, state_q == ST_DONE && out_free, m_tvalid && s_tready)

endmodule

`default_nettype wire

// ===== sim/tb_extent_range_lookup_core.sv =====
// Self-checking testbench for extent_range_lookup_core: extent table writes and sector lookups.
`timescale 1ns / 100ps

module tb_extent_range_lookup_core;

	// One request as the sender sees it, before packing.
	typedef struct packed {
		logic                       mode;
		logic [erl_pkg::SECT_W-1:0] sector;
		logic [erl_pkg::SLOT_W-1:0] slot;
		logic [erl_pkg::SECT_W-1:0] start;
		logic [erl_pkg::SECT_W-1:0] len;
		logic [erl_pkg::SECT_W-1:0] base;
		logic [erl_pkg::DISK_W-1:0] disk;
	} req_t;

	// Translation outcome of one lookup.
	typedef struct packed {
		logic                       hit;
		logic [erl_pkg::DISK_W-1:0] disk;
		logic [erl_pkg::PHYS_W-1:0] phys;
	} xlat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [erl_pkg::S_TDATA_W-1:0]   s_tdata = '0;
	logic [0:0]                      s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [erl_pkg::M_TDATA_W-1:0]   m_tdata;
	logic [0:0]                      m_tuser;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [erl_pkg::ACTIVE_W-1:0]    cfg_data = '0;

	// Shadow of the extent table and of active_entries, updated at acceptance.
	logic [erl_pkg::SECT_W-1:0]   tab_start [erl_pkg::TABLE_ENTRIES];
	logic [erl_pkg::SECT_W-1:0]   tab_len   [erl_pkg::TABLE_ENTRIES];
	logic [erl_pkg::SECT_W-1:0]   tab_base  [erl_pkg::TABLE_ENTRIES];
	logic [erl_pkg::DISK_W-1:0]   tab_disk  [erl_pkg::TABLE_ENTRIES];
	logic [erl_pkg::ACTIVE_W-1:0] active_cnt = '0;

	req_t  pend_q[$];   // requests waiting for the driver
	xlat_t xlat_q[$];   // translations still owed by the block
	req_t  drv_req;     // request currently presented on s_*

	int n_queued   = 0;
	int n_taken    = 0;
	int n_lookups  = 0;
	int n_writes   = 0;
	int n_hits     = 0;
	int n_checked  = 0;
	int n_cfg      = 0;
	int n_errors   = 0;
	int src_idle_pct = 9;
	int snk_idle_pct = 54;

	extent_range_lookup_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the block hangs; far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Translation predictor: first active extent with start <= s < start+len.
	// The range end is formed at 49 bits so it never wraps.
	// ---------------------------------------------------------------------
	function automatic xlat_t translate_sector(input logic [erl_pkg::SECT_W-1:0] sec);
		xlat_t                      res;
		int                         lim;
		logic                       found;
		logic [erl_pkg::PHYS_W-1:0] span_end;
		res = '0;
		found = 1'b0;
		lim = (int'(active_cnt) > erl_pkg::TABLE_ENTRIES)
			? erl_pkg::TABLE_ENTRIES : int'(active_cnt);
		for (int i = 0; i < lim; i++) begin
			span_end = {1'b0, tab_start[i]} + {1'b0, tab_len[i]};
			if (!found && sec >= tab_start[i] && {1'b0, sec} < span_end) begin
				found = 1'b1;
				res.hit = 1'b1;
				res.disk = tab_disk[i];
				res.phys = {1'b0, tab_base[i]} + {1'b0, sec - tab_start[i]};
			end
		end
		return res;
	endfunction

	// Apply an accepted request to the shadow table or owe a translation.
	task automatic apply_request(input req_t r);
		if (r.mode == erl_pkg::MODE_WRITE) begin
			if (int'(r.slot) < erl_pkg::TABLE_ENTRIES) begin
				tab_start[r.slot] = r.start;
				tab_len[r.slot]   = r.len;
				tab_base[r.slot]  = r.base;
				tab_disk[r.slot]  = r.disk;
			end
			n_writes++;
		end else begin
			xlat_q.push_back(translate_sector(r.sector));
			n_lookups++;
		end
	endtask

	function automatic logic [erl_pkg::S_TDATA_W-1:0] pack_request(input req_t r);
		logic [erl_pkg::S_TDATA_W-1:0] d;
		d = '0;
		d[erl_pkg::SECTOR_LSB +: erl_pkg::SECT_W] = r.sector;
		d[erl_pkg::SLOT_LSB   +: erl_pkg::SLOT_W] = r.slot;
		d[erl_pkg::START_LSB  +: erl_pkg::SECT_W] = r.start;
		d[erl_pkg::LENGTH_LSB +: erl_pkg::SECT_W] = r.len;
		d[erl_pkg::BASE_LSB   +: erl_pkg::SECT_W] = r.base;
		d[erl_pkg::DISK_LSB   +: erl_pkg::DISK_W] = r.disk;
		return d;
	endfunction

	// ---------------------------------------------------------------------
	// Driver: presents the next pending request, random gaps per src_idle_pct.
	// Prediction happens at the edge where the request is taken.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				apply_request(drv_req);
				n_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pend_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					drv_req = pend_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= pack_request(drv_req);
					s_tuser  <= drv_req.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: checks each response against the oldest owed translation and
	// throttles m_tready per snk_idle_pct.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		xlat_t want;
		xlat_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.hit  = m_tuser[0];
				got.disk = m_tdata[0 +: erl_pkg::DISK_W];
				got.phys = m_tdata[erl_pkg::DISK_W +: erl_pkg::PHYS_W];
				if (xlat_q.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected response, actual hit=%0b disk=%0d phys=%h",
						$time, got.hit, got.disk, got.phys);
				end else begin
					want = xlat_q.pop_front();
					n_checked++;
					if (got.hit !== want.hit) begin
						n_errors++;
						$display("%0t: hit mismatch, expected %0b actual %0b",
							$time, want.hit, got.hit);
					end
					if (got.disk !== want.disk) begin
						n_errors++;
						$display("%0t: disk_index mismatch, expected %0d actual %0d",
							$time, want.disk, got.disk);
					end
					if (got.phys !== want.phys) begin
						n_errors++;
						$display("%0t: physical_sector mismatch, expected %h actual %h",
							$time, want.phys, got.phys);
					end
					if (want.hit)
						n_hits++;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	function automatic logic [erl_pkg::SECT_W-1:0] rand_sector();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[erl_pkg::SECT_W-1:0];
	endfunction

	function automatic req_t lookup_req(input logic [erl_pkg::SECT_W-1:0] sec);
		req_t r;
		r = '0;
		r.mode = erl_pkg::MODE_LOOKUP;
		r.sector = sec;
		// unused fields carry noise; the block must ignore them
		r.slot = erl_pkg::SLOT_W'($urandom_range(0, 15));
		r.start = rand_sector();
		r.len = rand_sector();
		r.base = rand_sector();
		r.disk = erl_pkg::DISK_W'($urandom_range(0, 3));
		return r;
	endfunction

	function automatic req_t write_req(input logic [erl_pkg::SLOT_W-1:0] slot,
			input logic [erl_pkg::SECT_W-1:0] start, input logic [erl_pkg::SECT_W-1:0] len,
			input logic [erl_pkg::SECT_W-1:0] base, input logic [erl_pkg::DISK_W-1:0] disk);
		req_t r;
		r.mode = erl_pkg::MODE_WRITE;
		r.sector = rand_sector();
		r.slot = slot;
		r.start = start;
		r.len = len;
		r.base = base;
		r.disk = disk;
		return r;
	endfunction

	// Random request. Lookups mostly aim inside or at the edges of a known
	// extent so that hits are common; the rest roam the full sector space.
	function automatic req_t random_req();
		int                         k;
		logic [63:0]                off;
		logic [erl_pkg::SECT_W-1:0] st;
		logic [erl_pkg::SECT_W-1:0] ln;
		logic [erl_pkg::SECT_W-1:0] sec;
		if ($urandom_range(0, 99) < 20) begin
			st = ($urandom_range(0, 1) == 0) ? rand_sector()
				: erl_pkg::SECT_W'($urandom_range(0, 4095));
			case ($urandom_range(0, 9))
				0:       ln = '0;
				1, 2, 3: ln = rand_sector();
				default: ln = erl_pkg::SECT_W'($urandom_range(1, 5000));
			endcase
			return write_req(erl_pkg::SLOT_W'($urandom_range(0, 15)), st, ln,
				rand_sector(), erl_pkg::DISK_W'($urandom_range(0, 3)));
		end
		k = $urandom_range(0, erl_pkg::TABLE_ENTRIES - 1);
		st = tab_start[k];
		ln = tab_len[k];
		case ($urandom_range(0, 9))
			6:       sec = st - 1'b1;
			7:       sec = st + ln;
			8, 9:    sec = rand_sector();
			default: begin
				off = (ln == '0) ? 64'd0 : ({$urandom, $urandom} % {16'd0, ln});
				sec = st + off[erl_pkg::SECT_W-1:0];
			end
		endcase
		return lookup_req(sec);
	endfunction

	task automatic enqueue(input req_t r);
		pend_q.push_back(r);
		n_queued++;
	endtask

	// Wait until every queued request is taken and every response checked,
	// then give a trailing write time to finish inside the block.
	task automatic wait_quiet();
		while (n_taken != n_queued || xlat_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// active_entries write; only called while the block is quiet.
	task automatic write_active(input logic [erl_pkg::ACTIVE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		active_cnt = val;
		n_cfg++;
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------
	initial begin
		logic [erl_pkg::ACTIVE_W-1:0] chunk_cfg [12];
		logic [erl_pkg::SECT_W-1:0]   max_sec;
		chunk_cfg = '{5'd31, 5'd0, 5'd16, 5'd1, 5'd9, 5'd31,
			5'd16, 5'd0, 5'd5, 5'd16, 5'd31, 5'd12};
		max_sec = '1;
		for (int i = 0; i < erl_pkg::TABLE_ENTRIES; i++) begin
			tab_start[i] = '0;
			tab_len[i]   = '0;
			tab_base[i]  = '0;
			tab_disk[i]  = '0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: with no active entries every lookup misses; then fill
		// the whole table before any scan can touch it.
		enqueue(lookup_req('0));
		enqueue(lookup_req(max_sec));
		enqueue(write_req(4'd0, 48'd0, 48'd0, 48'd77, 2'd3));          // zero length
		enqueue(write_req(4'd1, 48'd0, 48'd10, max_sec, 2'd2));         // base at top
		enqueue(write_req(4'd2, 48'd100, 48'd50, 48'd1000, 2'd1));
		enqueue(write_req(4'd3, 48'd120, 48'd100, 48'd5000, 2'd3));     // overlaps slot 2
		enqueue(write_req(4'd4, max_sec - 48'd15, max_sec, 48'd0, 2'd0)); // end past 2^48
		enqueue(write_req(4'd5, 48'd5, 48'd1, 48'd9, 2'd0));            // shadowed by slot 1
		for (int i = 6; i < erl_pkg::TABLE_ENTRIES; i++)
			enqueue(write_req(erl_pkg::SLOT_W'(i),
				erl_pkg::SECT_W'($urandom_range(300, 60000)),
				erl_pkg::SECT_W'($urandom_range(1, 3000)), rand_sector(),
				erl_pkg::DISK_W'($urandom_range(0, 3))));
		wait_quiet();

		// Directed lookups over the full table.
		write_active(5'd16);
		enqueue(lookup_req(48'd0));            // slot 1, physical at the 48-bit maximum
		enqueue(lookup_req(48'd9));
		enqueue(lookup_req(48'd5));            // first match wins over slot 5
		enqueue(lookup_req(48'd149));          // slot 2 wins over slot 3
		enqueue(lookup_req(48'd150));          // falls to slot 3
		enqueue(lookup_req(48'd220));          // just past slot 3
		enqueue(lookup_req(max_sec));          // slot 4, no wrap of range end
		enqueue(lookup_req(max_sec - 48'd16)); // just below slot 4
		wait_quiet();

		// Random chunks; each chunk ends with a full drain, which doubles as
		// the sender pause, and the next one starts on a new register value.
		for (int c = 0; c < 12; c++) begin
			if (c < 4) begin
				src_idle_pct = 9;
				snk_idle_pct = 54;
			end else if (c < 8) begin
				src_idle_pct = 54;
				snk_idle_pct = 9;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			write_active(chunk_cfg[c]);
			for (int i = 0; i < 45; i++)
				enqueue(random_req());
			wait_quiet();
		end

		$display("Covered %0d lookups (%0d hits) and %0d table writes over %0d settings",
			n_lookups, n_hits, n_writes, n_cfg);
		$display("of active_entries, including 0, 16 and the saturating 31; %0d checked.",
			n_checked);
		if (n_errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
